// ===== hw/rtl/trsm_pkg.sv =====
// Shared types and constants for the tilt-rotor servo mixer.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package trsm_pkg;

   // Fraction bits of the stored conversion position (8 to 24).
   localparam int POSITION_FRACTION_BITS = 16;

   localparam int STICK_W  = 11;
   localparam int DRIVE_W  = 24;
   localparam int LEVEL_W  = 10;
   localparam int SERVO_W  = 12;
   localparam int PULSE_W  = 11;
   localparam int CORR_W   = 9;

   // The position holds 11 integer bits; a distance inside the span needs 9.
   localparam int POS_W    = 11 + POSITION_FRACTION_BITS;
   localparam int DELTA_W  = 9 + POSITION_FRACTION_BITS;

   localparam int HOVER_POS     = 1100;
   localparam int FORWARD_POS   = 1500;
   localparam int STICK_LIMIT   = 100;
   localparam int LEVEL_MAX     = 1000;
   localparam int ROLL_LIMIT    = 250;
   localparam int YAW_LIMIT     = 166;
   localparam int PULSE_LOW     = 1000;
   localparam int PULSE_HIGH    = 2000;
   localparam int SERVO_MIN     = 584;
   localparam int SERVO_MAX     = 2416;

   localparam logic [POS_W-1:0] HOVER_Q   = POS_W'(HOVER_POS) << POSITION_FRACTION_BITS;
   localparam logic [POS_W-1:0] FORWARD_Q = POS_W'(FORWARD_POS) << POSITION_FRACTION_BITS;

   // Easing divides the distance to the target by this constant.
   localparam int DIVISOR  = 100;
   localparam int REM_W    = $clog2(DIVISOR);

   // Serial multiplier geometry: the weight is at most 20 * 1000.
   localparam int WEIGHT_W   = 15;
   localparam int PROD_W     = DRIVE_W + WEIGHT_W;
   localparam int DRIVE_FRAC = 12;
   localparam int SCALED_W   = PROD_W - DRIVE_FRAC;

   localparam int CNT_W = $clog2(DELTA_W + WEIGHT_W);

   typedef struct packed {
      logic signed [STICK_W-1:0] stick_command;
      logic signed [DRIVE_W-1:0] roll_drive;
      logic signed [DRIVE_W-1:0] pitch_drive;
      logic signed [DRIVE_W-1:0] yaw_drive;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] conversion_level;
      logic [SERVO_W-1:0] servo_one;
      logic [SERVO_W-1:0] servo_two;
      logic [SERVO_W-1:0] servo_three;
      logic [SERVO_W-1:0] servo_four;
   } rsp_type;

   // Sequencer commands to a serial arithmetic unit.
   typedef struct packed {
      logic load;
      logic step;
   } serial_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tilt_rotor_servo_mixer.sv =====
// Top level of the tilt-rotor conversion tracker and servo mixer.
// Depends on trsm_pkg, trsm_serial_div and trsm_serial_mul.
//
//   Channel  Direction  Ports                          Word
//   request  in         req_valid, req_stall, req_word  stick and three drives
//   response out        rsp_valid, rsp_stall, rsp_word  level and four servo widths
//
// One word is worked on at a time. A dead-band word passes through the level,
// load, multiply, round and mix states before the next acceptance; a word that
// moves the position first passes through the one-bit-per-cycle divider that
// eases the position and the update state; the multipliers are serial.
// Reset sets the position to hover (1100.0) and empties the response register.
// A waiting response does not block the next word; only the final mixing step
// waits for the response register to drain.
`default_nettype none

module tilt_rotor_servo_mixer
   import trsm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_word
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_UPD   = 3'd2;
   localparam logic [2:0] ST_LEVEL = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_ROUND = 3'd6;
   localparam logic [2:0] ST_MIX   = 3'd7;

   localparam int UP_W = DELTA_W + 4 - (POSITION_FRACTION_BITS + 1);
   localparam logic [DELTA_W+3:0] ROUND_ADD =
      (DELTA_W+4)'((64'd1 << (POSITION_FRACTION_BITS + 1)) - 64'd1);

   // Q12 product back to an integer, rounding toward zero.
   function automatic logic signed [SCALED_W-1:0] q12_trunc(
      input logic signed [PROD_W-1:0] p);
      logic signed [SCALED_W-1:0] fl;
      logic                       frac_nz;
      fl      = p[PROD_W-1:DRIVE_FRAC];
      frac_nz = |p[DRIVE_FRAC-1:0];
      return (p[PROD_W-1] && frac_nz) ? fl + SCALED_W'(1) : fl;
   endfunction

   function automatic logic signed [CORR_W-1:0] clamp_sym(
      input logic signed [SCALED_W-1:0] v,
      input int                         lim);
      logic signed [CORR_W-1:0] r;
      if (v > lim)       r = CORR_W'(lim);
      else if (v < -lim) r = CORR_W'(-lim);
      else               r = v[CORR_W-1:0];
      return r;
   endfunction

   // One servo lane: clamp the base plus or minus pitch, subtract roll, add yaw.
   function automatic logic [SERVO_W-1:0] mix_lane(
      input logic        [PULSE_W-1:0]  base,
      input logic signed [SCALED_W-1:0] pitch,
      input logic                       negate,
      input logic signed [CORR_W-1:0]   roll,
      input logic signed [CORR_W-1:0]   yaw);
      logic signed [SCALED_W:0]  pe;
      logic signed [SCALED_W:0]  t;
      logic        [PULSE_W-1:0] s;
      logic signed [SERVO_W:0]   v;
      pe = (SCALED_W+1)'(pitch);
      t  = $signed({{(SCALED_W+1-PULSE_W){1'b0}}, base}) + (negate ? -pe : pe);
      if (t < PULSE_LOW)       s = PULSE_W'(PULSE_LOW);
      else if (t > PULSE_HIGH) s = PULSE_W'(PULSE_HIGH);
      else                     s = t[PULSE_W-1:0];
      v = $signed({2'b00, s}) - (SERVO_W+1)'(roll) + (SERVO_W+1)'(yaw);
      return v[SERVO_W-1:0];
   endfunction

   logic [2:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        dir_up_ff, dir_up_in;
   logic [POS_W-1:0]            pos_ff, pos_in;
   req_type                     word_ff, word_in;
   logic [LEVEL_W-1:0]          level_ff, level_in;
   logic signed [CORR_W-1:0]    roll_ff, roll_in;
   logic signed [CORR_W-1:0]    yaw_ff, yaw_in;
   logic signed [SCALED_W-1:0]  pitch_ff, pitch_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_word_ff, rsp_word_in;

   logic                        req_accept;
   logic                        stick_up, stick_down;
   logic [DELTA_W-1:0]          div_dividend, quotient;
   serial_ctl_type              div_ctl, mul_ctl;

   logic [DELTA_W-1:0]          fwd_gap;
   logic [DELTA_W+2:0]          dist_x5;
   logic [DELTA_W+3:0]          dist_round;
   logic [UP_W-1:0]             up;
   logic [LEVEL_W-1:0]          level_calc;
   logic [WEIGHT_W-1:0]         weight_tilt, weight_yaw;
   logic signed [PROD_W-1:0]    roll_prod, pitch_prod, yaw_prod;
   logic [PULSE_W-1:0]          base_low, base_high;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign stick_up   = req_word.stick_command > STICK_LIMIT;
   assign stick_down = req_word.stick_command < -STICK_LIMIT;

   // Distance to the chosen target; the position never leaves the span.
   assign div_dividend = stick_up ? DELTA_W'(FORWARD_Q - pos_ff)
                                  : DELTA_W'(pos_ff - HOVER_Q);

   // Level is 1000 minus the rounded-up distance to forward flight times 2.5.
   always_comb begin
      fwd_gap    = DELTA_W'(FORWARD_Q - pos_ff);
      dist_x5    = {fwd_gap, 2'b00} + (DELTA_W+3)'(fwd_gap);
      dist_round = (DELTA_W+4)'(dist_x5) + ROUND_ADD;
      up         = dist_round[DELTA_W+3:POSITION_FRACTION_BITS+1];
      if (pos_ff < HOVER_Q)
         level_calc = '0;
      else if (pos_ff > FORWARD_Q)
         level_calc = LEVEL_W'(LEVEL_MAX);
      else if (up > UP_W'(LEVEL_MAX))
         level_calc = '0;
      else
         level_calc = LEVEL_W'(UP_W'(LEVEL_MAX) - up);
   end

   // Tilt weight (1000 - level) * 2 and yaw weight level * 20.
   assign weight_tilt = WEIGHT_W'({LEVEL_W'(LEVEL_W'(LEVEL_MAX) - level_ff), 1'b0});
   assign weight_yaw  = WEIGHT_W'({level_ff, 4'b0000}) + WEIGHT_W'({level_ff, 2'b00});

   assign base_low  = PULSE_W'(PULSE_LOW) + PULSE_W'(level_ff);
   assign base_high = PULSE_W'(PULSE_HIGH) - PULSE_W'(level_ff);

   trsm_serial_div u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .quotient (quotient)
   );

   trsm_serial_mul u_mul_roll (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (word_ff.roll_drive),
      .weight       (weight_tilt),
      .product      (roll_prod)
   );

   trsm_serial_mul u_mul_pitch (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (word_ff.pitch_drive),
      .weight       (weight_tilt),
      .product      (pitch_prod)
   );

   trsm_serial_mul u_mul_yaw (
      .clock        (clock),
      .ctl          (mul_ctl),
      .multiplicand (word_ff.yaw_drive),
      .weight       (weight_yaw),
      .product      (yaw_prod)
   );

   // Sequencer: ease the position if commanded, derive level, weight drives, mix.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dir_up_in    = dir_up_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      level_in     = level_ff;
      roll_in      = roll_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_ctl      = '0;
      mul_ctl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               word_in      = req_word;
               dir_up_in    = stick_up;
               cnt_in       = '0;
               div_ctl.load = 1'b1;
               state_in     = (stick_up || stick_down) ? ST_DIV : ST_LEVEL;
            end
         end
         ST_DIV: begin
            div_ctl.step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DELTA_W - 1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            pos_in   = dir_up_ff ? pos_ff + POS_W'(quotient) : pos_ff - POS_W'(quotient);
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            level_in = level_calc;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            mul_ctl.load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            mul_ctl.step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WEIGHT_W - 1)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            roll_in  = clamp_sym(q12_trunc(roll_prod), ROLL_LIMIT);
            yaw_in   = clamp_sym(q12_trunc(yaw_prod), YAW_LIMIT);
            pitch_in = q12_trunc(pitch_prod);
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // Waits only while the previous response is still held.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in.conversion_level = level_ff;
               rsp_word_in.servo_one   = mix_lane(base_low,  pitch_ff, 1'b0, roll_ff, yaw_ff);
               rsp_word_in.servo_two   = mix_lane(base_high, pitch_ff, 1'b0, roll_ff, yaw_ff);
               rsp_word_in.servo_three = mix_lane(base_high, pitch_ff, 1'b1, roll_ff, yaw_ff);
               rsp_word_in.servo_four  = mix_lane(base_low,  pitch_ff, 1'b1, roll_ff, yaw_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         dir_up_ff    <= 1'b0;
         pos_ff       <= HOVER_Q;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dir_up_ff    <= dir_up_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      level_ff    <= level_in;
      roll_ff     <= roll_in;
      yaw_ff      <= yaw_in;
      pitch_ff    <= pitch_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // Easing never carries the position past either end of its span.
   a_pos_in_span: assert property (@(posedge clock) disable iff (reset)
      pos_ff >= HOVER_Q && pos_ff <= FORWARD_Q)
      else $error("conversion position left its span");

   // A stick inside the dead band leaves the position alone for the whole word.
   a_dead_band_holds: assert property (@(posedge clock) disable iff (reset)
      req_accept && !stick_up && !stick_down |=> state_ff == ST_LEVEL && $stable(pos_ff))
      else $error("dead-band word changed the position");

   // A held response is not overwritten by the mixing step.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("stalled response was overwritten");

   // Every response keeps its level and servos one and four in the mixer's ranges.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.conversion_level <= LEVEL_MAX
                    && rsp_word_ff.servo_one >= SERVO_MIN
                    && rsp_word_ff.servo_one <= SERVO_MAX
                    && rsp_word_ff.servo_four >= SERVO_MIN
                    && rsp_word_ff.servo_four <= SERVO_MAX)
      else $error("response out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/trsm_serial_div.sv =====
// Bit-serial restoring divider by the constant DIVISOR, one quotient bit per cycle.
// Depends on trsm_pkg.
`default_nettype none

module trsm_serial_div
   import trsm_pkg::*;
(
   input  wire logic               clock,
   input  wire serial_ctl_type     ctl,
   input  wire logic [DELTA_W-1:0] dividend,
   output logic      [DELTA_W-1:0] quotient
);

   // Dividend bits leave at the top while quotient bits enter at the bottom.
   logic [DELTA_W-1:0] dq_ff, dq_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [REM_W:0]     trial;
   logic               fits;

   always_comb begin
      trial  = {rem_ff, dq_ff[DELTA_W-1]};
      fits   = trial >= (REM_W+1)'(DIVISOR);
      dq_in  = dq_ff;
      rem_in = rem_ff;
      if (ctl.load) begin
         dq_in  = dividend;
         rem_in = '0;
      end else if (ctl.step) begin
         dq_in  = {dq_ff[DELTA_W-2:0], fits};
         rem_in = fits ? REM_W'(trial - (REM_W+1)'(DIVISOR)) : trial[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign quotient = dq_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/trsm_serial_mul.sv =====
// Bit-serial signed-by-unsigned multiplier, one weight bit per cycle, LSB first.
// Depends on trsm_pkg.
`default_nettype none

module trsm_serial_mul
   import trsm_pkg::*;
(
   input  wire logic                       clock,
   input  wire serial_ctl_type             ctl,
   input  wire logic signed [DRIVE_W-1:0]  multiplicand,
   input  wire logic        [WEIGHT_W-1:0] weight,
   output logic signed      [PROD_W-1:0]   product
);

   // The low register starts as the weight and fills with product bits.
   logic signed [DRIVE_W-1:0] hi_ff, hi_in;
   logic [WEIGHT_W-1:0]       lo_ff, lo_in;
   logic signed [DRIVE_W:0]   sum;

   always_comb begin
      sum   = lo_ff[0] ? (DRIVE_W+1)'(hi_ff) + (DRIVE_W+1)'(multiplicand)
                       : (DRIVE_W+1)'(hi_ff);
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (ctl.load) begin
         hi_in = '0;
         lo_in = weight;
      end else if (ctl.step) begin
         hi_in = sum[DRIVE_W:1];
         lo_in = {sum[0], lo_ff[WEIGHT_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign product = {hi_ff, lo_ff};

endmodule

`default_nettype wire
